/* hdl/enp_pkg.sv */
// Shared widths, register codes and word types of the elastic-net proximal operator.
package enp_pkg;

	// Fixed-point format of coefficients, strength and step size.
	localparam int FRAC_BITS  = 16;
	localparam int COEF_W     = 32;
	localparam int PEN_W      = 63;
	localparam int STR_W      = 32;
	localparam int STEP_W     = 32;
	localparam int RATIO_W    = 17;
	localparam int RATIO_FRAC = 16;
	localparam int CFG_DATA_W = 32;
	localparam int REG_IDX_W  = 2;

	localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(1) << RATIO_FRAC;
	localparam logic [STEP_W-1:0]  STEP_RESET = STEP_W'(1) << FRAC_BITS;

	// step_size * strength and its products with the ratio.
	localparam int SS_W     = STR_W + STEP_W;
	localparam int HALF_W   = 32;
	localparam int PP_W     = HALF_W + RATIO_W;
	localparam int PROD_W   = SS_W + RATIO_W;
	localparam int THR_SH   = FRAC_BITS + RATIO_FRAC;
	localparam int THR_RAW_W = PROD_W - THR_SH;
	localparam int THR_W    = 32;
	localparam int DEN_W    = THR_RAW_W + 1;

	// Squared coefficient magnitude and the quadratic penalty term.
	localparam int SQ_W     = 2 * COEF_W - 1;
	localparam int SQ_HI_W  = SQ_W - HALF_W;
	localparam int SQ_PA_W  = HALF_W + RATIO_W;
	localparam int SQ_PB_W  = SQ_HI_W + RATIO_W;
	localparam int SQ_P_W   = SQ_PB_W + HALF_W;
	localparam int PEN_SH   = FRAC_BITS + RATIO_FRAC + 1;
	localparam int L1_W     = COEF_W + RATIO_W;

	// Division: numerator (|x| - T) << FRAC_BITS, one quotient bit per cell.
	localparam int NUM_W    = COEF_W + FRAC_BITS;
	localparam int QUO_W    = COEF_W;
	localparam int REM_W    = DEN_W;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_STRENGTH  = 2'd0,
		REG_MIX_RATIO = 2'd1,
		REG_STEP_SIZE = 2'd2,
		REG_POS_ONLY  = 2'd3
	} reg_idx_t;

	// Values derived from the configuration registers.
	typedef struct packed {
		logic [THR_W-1:0]   thr;
		logic [DEN_W-1:0]   den;
		logic [RATIO_W-1:0] ratio;
		logic [RATIO_W-1:0] ratio_c;
		logic               pos_only;
	} enp_params_t;

	// Word handed from one division cell to the next.
	typedef struct packed {
		logic             neg;
		logic [REM_W-1:0] rem;
		logic [QUO_W-1:0] work;
		logic [PEN_W-1:0] pen;
	} enp_word_t;

endpackage

/* hdl/enp_cfg.sv */
// Configuration registers and the threshold and denominator derived from them.
module enp_cfg (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_we,
	input  logic [enp_pkg::REG_IDX_W-1:0]     cfg_index,
	input  logic [enp_pkg::CFG_DATA_W-1:0]    cfg_wdata,
	output enp_pkg::enp_params_t              params
);
	import enp_pkg::*;

	logic [STR_W-1:0]   strength_q;
	logic [RATIO_W-1:0] mix_q;
	logic [STEP_W-1:0]  step_q;
	logic               pos_q;

	logic [SS_W-1:0]    ss_q;
	logic [RATIO_W-1:0] r_q;
	logic [RATIO_W-1:0] rc_q;
	logic [PP_W-1:0]    thr_lo_q;
	logic [PP_W-1:0]    thr_hi_q;
	logic [PP_W-1:0]    den_lo_q;
	logic [PP_W-1:0]    den_hi_q;
	logic [THR_W-1:0]   thr_q;
	logic [DEN_W-1:0]   den_q;

	logic [PROD_W-1:0]    thr_sum;
	logic [PROD_W-1:0]    den_sum;
	logic [THR_RAW_W-1:0] thr_raw;
	logic [THR_RAW_W-1:0] den_raw;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strength_q <= '0;
			mix_q      <= '0;
			step_q     <= STEP_RESET;
			pos_q      <= 1'b0;
		end else if (cfg_we) begin
			case (reg_idx_t'(cfg_index))
				REG_STRENGTH:  strength_q <= cfg_wdata[STR_W-1:0];
				REG_MIX_RATIO: mix_q      <= cfg_wdata[RATIO_W-1:0];
				REG_STEP_SIZE: step_q     <= cfg_wdata[STEP_W-1:0];
				REG_POS_ONLY:  pos_q      <= cfg_wdata[0];
				default: ;
			endcase
		end
	end

	// A ratio above one acts as one.
	always_ff @(posedge clk) begin
		ss_q     <= step_q * strength_q;
		r_q      <= (mix_q > RATIO_ONE) ? RATIO_ONE : mix_q;
		rc_q     <= RATIO_ONE - ((mix_q > RATIO_ONE) ? RATIO_ONE : mix_q);
		thr_lo_q <= ss_q[HALF_W-1:0] * r_q;
		thr_hi_q <= ss_q[SS_W-1:HALF_W] * r_q;
		den_lo_q <= ss_q[HALF_W-1:0] * rc_q;
		den_hi_q <= ss_q[SS_W-1:HALF_W] * rc_q;
		thr_q    <= (|thr_raw[THR_RAW_W-1:THR_W]) ? '1 : thr_raw[THR_W-1:0];
		den_q    <= DEN_W'(den_raw) + (DEN_W'(1) << FRAC_BITS);
	end

	assign thr_sum = {thr_hi_q, HALF_W'(0)} + PROD_W'(thr_lo_q);
	assign den_sum = {den_hi_q, HALF_W'(0)} + PROD_W'(den_lo_q);
	assign thr_raw = thr_sum[PROD_W-1:THR_SH];
	assign den_raw = den_sum[PROD_W-1:THR_SH];

	assign params.thr      = thr_q;
	assign params.den      = den_q;
	assign params.ratio    = r_q;
	assign params.ratio_c  = rc_q;
	assign params.pos_only = pos_q;

endmodule

/* hdl/enp_cell.sv */
// One restoring-division cell: settles one quotient bit and passes the word on.
module enp_cell (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [enp_pkg::DEN_W-1:0]     den,
	input  logic                          in_valid,
	input  enp_pkg::enp_word_t            in_word,
	output logic                          out_valid,
	output enp_pkg::enp_word_t            out_word
);
	import enp_pkg::*;

	logic             valid_q;
	enp_word_t        word_q;
	logic [REM_W:0]   trial;
	logic [REM_W:0]   diff;
	logic             ge;

	// Bring down the next dividend bit and try to subtract the divisor.
	assign trial = {in_word.rem, in_word.work[QUO_W-1]};
	assign ge    = trial >= {1'b0, den};
	assign diff  = trial - {1'b0, den};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		word_q.neg  <= in_word.neg;
		word_q.pen  <= in_word.pen;
		word_q.rem  <= ge ? diff[REM_W-1:0] : trial[REM_W-1:0];
		word_q.work <= {in_word.work[QUO_W-2:0], ge};
	end

	assign out_valid = valid_q;
	assign out_word  = word_q;

endmodule

/* hdl/elastic_net_prox_operator_top.sv */
// Top level of the elastic-net proximal operator: front stages, division chain, result register.
//
//  Channel   Direction  Handshake             Payload
//  ------    ---------  --------------------  ------------------------------------
//  command   in         start, busy           coef_in
//  result    out        done (one cycle)      prox_out, penalty_out
//  config    in         cfg_we (no wait)      cfg_index, cfg_wdata
//
// One coefficient word is taken in every cycle; busy is never raised.
// Each result passes through five front stages,
// 32 division cells that each settle one quotient bit, and the result register.
// The division chain is the longest part of the pipeline; the rate is one word per clock.
// Reset sets the configuration to its defaults (step size one, the rest zero) and clears
// all valid flags; words in flight are dropped. The receiver cannot stall, so nothing ever holds in the pipeline.
module elastic_net_prox_operator_top (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic signed [enp_pkg::COEF_W-1:0]    coef_in,
	output logic                                 done,
	output logic signed [enp_pkg::COEF_W-1:0]    prox_out,
	output logic [enp_pkg::PEN_W-1:0]            penalty_out,
	input  logic                                 cfg_we,
	input  logic [enp_pkg::REG_IDX_W-1:0]        cfg_index,
	input  logic [enp_pkg::CFG_DATA_W-1:0]       cfg_wdata
);
	import enp_pkg::*;

	enp_params_t params;

	// Front pipeline registers.
	logic                      v_s1, v_s2, v_s3, v_s4, v_s5;
	logic signed [COEF_W-1:0]  coef_s1;
	logic [COEF_W-1:0]         mag_s2, mag_s3, mag_s4;
	logic                      neg_s2, neg_s3, neg_s4, neg_s5;
	logic [SQ_W-1:0]           sq_s3;
	logic [SQ_PA_W-1:0]        pa_s4;
	logic [SQ_PB_W-1:0]        pb_s4;
	logic [L1_W-1:0]           l1_s4;
	logic [PEN_W-1:0]          pen_s5;
	logic [NUM_W-1:0]          num_s5;

	logic [2*COEF_W-1:0]       sq_full;
	logic [SQ_P_W-1:0]         sq_prod;
	logic [COEF_W-1:0]         diff;
	logic                      pass;

	// Division chain taps.
	logic                      chain_valid [0:QUO_W];
	enp_word_t                 chain_word  [0:QUO_W];

	// Result register.
	logic                      done_q;
	logic signed [COEF_W-1:0]  prox_q;
	logic [PEN_W-1:0]          pen_q;

	enp_cfg u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.params    (params)
	);

	// The block keeps no state between words, so it is always ready.
	assign busy = 1'b0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1 <= 1'b0;
			v_s2 <= 1'b0;
			v_s3 <= 1'b0;
			v_s4 <= 1'b0;
			v_s5 <= 1'b0;
		end else begin
			v_s1 <= start && !busy;
			v_s2 <= v_s1;
			v_s3 <= v_s2;
			v_s4 <= v_s3;
			v_s5 <= v_s4;
		end
	end

	// The squared magnitude goes through one 32 by 32 multiplier; the penalty
	// weights are then applied in two halves so each product stays narrow.
	assign sq_full = mag_s2 * mag_s2;
	assign sq_prod = {pb_s4, HALF_W'(0)} + SQ_P_W'(pa_s4);

	// A coefficient survives only if it is nonzero, allowed by the sign mode
	// and larger than the threshold. Otherwise the numerator is zero, which
	// makes the quotient and the proximal value zero.
	assign pass = (mag_s4 != '0) && !(neg_s4 && params.pos_only) && (mag_s4 > params.thr);
	assign diff = mag_s4 - params.thr;

	always_ff @(posedge clk) begin
		coef_s1 <= coef_in;

		mag_s2  <= coef_s1[COEF_W-1] ? (COEF_W'(0) - $unsigned(coef_s1)) : $unsigned(coef_s1);
		neg_s2  <= coef_s1[COEF_W-1];

		sq_s3   <= sq_full[SQ_W-1:0];
		mag_s3  <= mag_s2;
		neg_s3  <= neg_s2;

		pa_s4   <= sq_s3[HALF_W-1:0] * params.ratio_c;
		pb_s4   <= sq_s3[SQ_W-1:HALF_W] * params.ratio_c;
		l1_s4   <= mag_s3 * params.ratio;
		mag_s4  <= mag_s3;
		neg_s4  <= neg_s3;

		pen_s5  <= PEN_W'(sq_prod[SQ_P_W-1:PEN_SH]) + PEN_W'(l1_s4[L1_W-1:RATIO_FRAC]);
		num_s5  <= pass ? {diff, FRAC_BITS'(0)} : '0;
		neg_s5  <= neg_s4;
	end

	// The upper numerator bits seed the remainder; they are always below the
	// divisor, which is at least one in this fixed-point format.
	assign chain_valid[0]     = v_s5;
	assign chain_word[0].neg  = neg_s5;
	assign chain_word[0].rem  = REM_W'(num_s5[NUM_W-1:QUO_W]);
	assign chain_word[0].work = num_s5[QUO_W-1:0];
	assign chain_word[0].pen  = pen_s5;

	for (genvar i = 0; i < QUO_W; i++) begin : g_cell
		enp_cell u_cell (
			.clk       (clk),
			.arst_n    (arst_n),
			.den       (params.den),
			.in_valid  (chain_valid[i]),
			.in_word   (chain_word[i]),
			.out_valid (chain_valid[i+1]),
			.out_word  (chain_word[i+1])
		);
	end

	// After the last cell the work field holds the quotient magnitude.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= chain_valid[QUO_W];
		end
	end

	always_ff @(posedge clk) begin
		prox_q <= chain_word[QUO_W].neg ? $signed(COEF_W'(0) - chain_word[QUO_W].work)
		                                : $signed(chain_word[QUO_W].work);
		pen_q  <= chain_word[QUO_W].pen;
	end

	assign done        = done_q;
	assign prox_out    = prox_q;
	assign penalty_out = pen_q;

`ifndef SYNTHESIS
	a_chain_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		v_s5 |-> ##QUO_W chain_valid[QUO_W])
		else $error("word entering the division chain did not reach its end");

	a_zero_penalty: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && (mag_s4 == '0)) |=> (pen_s5 == '0))
		else $error("zero coefficient produced a nonzero penalty");

	a_zero_numerator: assert property (@(posedge clk) disable iff (!arst_n)
		(v_s4 && (mag_s4 == '0)) |=> (num_s5 == '0))
		else $error("zero coefficient produced a nonzero numerator");
`endif

endmodule
